### hw/rtl/semp_pkg.sv
// ============================================================================
// semp_pkg - servo eased motion profile shared definitions
// Types, codes and fixed constants used by the controller, datapath and top.
// ============================================================================
`default_nettype none

package semp_pkg;

   // field widths
   localparam int DEG_W      = 9;
   localparam int DUR_W      = 16;
   localparam int MODE_W     = 2;
   localparam int PER_W      = 8;
   localparam int POS_W      = 25;
   localparam int PULSE_W    = 12;
   localparam int POS_FRAC   = 16;
   localparam int IDX_W      = 2;
   localparam int CFG_W      = 16;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   // register indexes
   localparam logic [IDX_W-1:0] REG_UPDATE_PERIOD   = 2'd0;
   localparam logic [IDX_W-1:0] REG_DEFAULT_TARGET  = 2'd1;
   localparam logic [IDX_W-1:0] REG_DEFAULT_DURATION = 2'd2;

   // register reset values
   localparam logic [PER_W-1:0] PERIOD_RST   = 8'd10;
   localparam logic [DEG_W-1:0] TARGET_RST   = 9'd140;
   localparam logic [DUR_W-1:0] DURATION_RST = 16'd5000;

   // easing modes
   localparam logic [MODE_W-1:0] CURVE_LIN    = 2'd0;
   localparam logic [MODE_W-1:0] CURVE_IN     = 2'd1;
   localparam logic [MODE_W-1:0] CURVE_DECEL  = 2'd2;
   localparam logic [MODE_W-1:0] CURVE_SMOOTH = 2'd3;

   localparam logic [DEG_W-1:0] MAX_DEG = 9'd270;
   localparam logic [PULSE_W-1:0] PULSE_BASE = 12'd500;

   // pulse offset = floor(floor(pos*25 >> 13) / 27); the /27 is done as
   // (x * 77673) >> 21, exact for x below 2^16
   localparam int               SCALE_SHIFT = 13;
   localparam int               RECIP_SHIFT = 21;
   localparam int               SCALE_X_W   = 16;
   localparam int               PULSE_OFS_W = 11;
   localparam logic [4:0]       SCALE_MUL   = 5'd25;
   localparam logic [16:0]      RECIP_MUL   = 17'd77673;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_DIV,
      S_SQ,
      S_CUBE,
      S_EASED,
      S_POS,
      S_PLACE,
      S_SCALE,
      S_RECIP,
      S_OUT
   } state_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_SQ,
      MUL_CUBE,
      MUL_POS,
      MUL_SCALE,
      MUL_RECIP
   } mul_op_type;

   typedef struct packed {
      logic       load;
      logic       div_init;
      logic       div_step;
      mul_op_type mul_op;
      logic       ease_lo;
      logic       ease_hi;
      logic       pos_wr;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } stat_type;

endpackage

`default_nettype wire

### hw/rtl/semp_ctrl.sv
// ============================================================================
// semp_ctrl - sequencer for the motion profile
// Steps one item through divide, easing, position and pulse scaling.
// ============================================================================
`default_nettype none

module semp_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   output semp_pkg::cmd_type   cmd,
   input  semp_pkg::stat_type  stat
);

   semp_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         semp_pkg::S_IDLE:   if (req_tvalid) state_in = semp_pkg::S_PREP;
         semp_pkg::S_PREP:   state_in = semp_pkg::S_DIV;
         semp_pkg::S_DIV:    if (stat.div_last) state_in = semp_pkg::S_SQ;
         semp_pkg::S_SQ:     state_in = semp_pkg::S_CUBE;
         semp_pkg::S_CUBE:   state_in = semp_pkg::S_EASED;
         semp_pkg::S_EASED:  state_in = semp_pkg::S_POS;
         semp_pkg::S_POS:    state_in = semp_pkg::S_PLACE;
         semp_pkg::S_PLACE:  state_in = semp_pkg::S_SCALE;
         semp_pkg::S_SCALE:  state_in = semp_pkg::S_RECIP;
         semp_pkg::S_RECIP:  state_in = semp_pkg::S_OUT;
         semp_pkg::S_OUT:    if (out_free) state_in = semp_pkg::S_IDLE;
         default:            state_in = semp_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.mul_op = semp_pkg::MUL_NONE;
      req_tready = 1'b0;
      case (state_ff)
         semp_pkg::S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         semp_pkg::S_PREP:  cmd.div_init = 1'b1;
         semp_pkg::S_DIV:   cmd.div_step = 1'b1;
         semp_pkg::S_SQ:    cmd.mul_op   = semp_pkg::MUL_SQ;
         semp_pkg::S_CUBE: begin
            cmd.mul_op  = semp_pkg::MUL_CUBE;
            cmd.ease_lo = 1'b1;
         end
         semp_pkg::S_EASED: cmd.ease_hi  = 1'b1;
         semp_pkg::S_POS:   cmd.mul_op   = semp_pkg::MUL_POS;
         semp_pkg::S_PLACE: cmd.pos_wr   = 1'b1;
         semp_pkg::S_SCALE: cmd.mul_op   = semp_pkg::MUL_SCALE;
         semp_pkg::S_RECIP: cmd.mul_op   = semp_pkg::MUL_RECIP;
         semp_pkg::S_OUT:   cmd.out_load = out_free;
         default:           cmd = '0;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= semp_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

### hw/rtl/semp_dpath.sv
// ============================================================================
// semp_dpath - motion profile datapath
// Move state, config registers, bit-serial divider, shared multiplier and
// the result register.
// ============================================================================
`default_nettype none

module semp_dpath #(
   parameter int FRAC_BITS = 16
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  semp_pkg::cmd_type                   cmd,
   output semp_pkg::stat_type                  stat,
   input  wire                                 req_action,
   input  wire  [semp_pkg::DEG_W-1:0]          req_goal_deg,
   input  wire  [semp_pkg::DUR_W-1:0]          req_duration_ms,
   input  wire  [semp_pkg::MODE_W-1:0]         req_ease_mode,
   input  wire                                 csr_wr,
   input  wire  [semp_pkg::IDX_W-1:0]          csr_index,
   input  wire  [semp_pkg::CFG_W-1:0]          csr_data,
   output logic [semp_pkg::PULSE_W-1:0]        rsp_pulse_us,
   output logic [semp_pkg::POS_W-1:0]          rsp_position_q16,
   output logic                                rsp_move_done
);

   localparam int TW  = FRAC_BITS + 1;
   localparam int KW  = FRAC_BITS + 2;
   localparam int OPW = (KW > semp_pkg::POS_W) ? KW : semp_pkg::POS_W;
   localparam int PW  = 2 * OPW;
   localparam int CW  = $clog2(FRAC_BITS);
   localparam int DW  = semp_pkg::DUR_W;
   localparam int PSW = semp_pkg::POS_W;

   localparam logic [TW-1:0] ONE_T   = TW'(1) << FRAC_BITS;
   localparam logic [KW-1:0] TWO_T   = KW'(2) << FRAC_BITS;
   localparam logic [KW-1:0] THREE_T = KW'(3) << FRAC_BITS;

   // config registers
   logic [semp_pkg::PER_W-1:0] period_ff;

   // move state
   logic [PSW-1:0]              cur_pos_ff, start_pos_ff;
   logic [semp_pkg::DEG_W-1:0]  goal_ff;
   logic [DW-1:0]               duration_ff, elapsed_ff;
   logic [semp_pkg::MODE_W-1:0] mode_ff;
   logic                        default_move_ff;

   // divider and easing
   logic [DW:0]           rem_ff;
   logic [FRAC_BITS-1:0]  quo_ff;
   logic [CW-1:0]         cnt_ff;
   logic                  full_ff;
   logic [TW-1:0]         ease_ff;
   logic [PW-1:0]         prod_ff;

   logic [DW-1:0]         dur_eff;
   logic [DW:0]           rem_dbl;
   logic                  rem_ge;
   logic [DW:0]           elapsed_sum;
   logic [TW-1:0]         t_val;
   logic [TW-1:0]         prod_frac;
   logic [PSW-1:0]        goal_q, mag_d, delta;
   logic                  moving_up;
   logic [OPW-1:0]        mul_a, mul_b;

   function automatic logic [semp_pkg::DEG_W-1:0] clamp_deg(
      input logic [semp_pkg::DEG_W-1:0] d
   );
      return (d > semp_pkg::MAX_DEG) ? semp_pkg::MAX_DEG : d;
   endfunction

   assign dur_eff     = (duration_ff == '0) ? DW'(1) : duration_ff;
   assign rem_dbl     = {rem_ff[DW-1:0], 1'b0};
   assign rem_ge      = rem_dbl >= {1'b0, dur_eff};
   assign elapsed_sum = {1'b0, elapsed_ff} + (DW+1)'(period_ff);
   assign t_val       = full_ff ? ONE_T : {1'b0, quo_ff};
   assign prod_frac   = prod_ff[FRAC_BITS +: TW];
   assign goal_q      = {goal_ff, {semp_pkg::POS_FRAC{1'b0}}};
   assign moving_up   = goal_q >= start_pos_ff;
   assign mag_d       = moving_up ? (goal_q - start_pos_ff) : (start_pos_ff - goal_q);
   assign delta       = prod_ff[FRAC_BITS +: PSW];

   assign stat.div_last = (cnt_ff == CW'(FRAC_BITS - 1));

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_op)
         semp_pkg::MUL_SQ: begin
            mul_a = OPW'(t_val);
            mul_b = (mode_ff == semp_pkg::CURVE_DECEL) ? OPW'(TWO_T - KW'(t_val))
                                                       : OPW'(t_val);
         end
         semp_pkg::MUL_CUBE: begin
            mul_a = OPW'(prod_frac);
            mul_b = OPW'(THREE_T - {t_val, 1'b0});
         end
         semp_pkg::MUL_POS: begin
            mul_a = OPW'(mag_d);
            mul_b = OPW'(ease_ff);
         end
         semp_pkg::MUL_SCALE: begin
            mul_a = OPW'(cur_pos_ff);
            mul_b = OPW'(semp_pkg::SCALE_MUL);
         end
         semp_pkg::MUL_RECIP: begin
            mul_a = OPW'(prod_ff[semp_pkg::SCALE_SHIFT +: semp_pkg::SCALE_X_W]);
            mul_b = OPW'(semp_pkg::RECIP_MUL);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_op != semp_pkg::MUL_NONE) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // config registers and move state
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff       <= semp_pkg::PERIOD_RST;
         cur_pos_ff      <= '0;
         start_pos_ff    <= '0;
         goal_ff         <= clamp_deg(semp_pkg::TARGET_RST);
         duration_ff     <= semp_pkg::DURATION_RST;
         mode_ff         <= semp_pkg::CURVE_LIN;
         elapsed_ff      <= '0;
         default_move_ff <= 1'b1;
      end else begin
         if (csr_wr) begin
            case (csr_index)
               semp_pkg::REG_UPDATE_PERIOD: begin
                  period_ff <= csr_data[semp_pkg::PER_W-1:0];
               end
               // default target/duration only steer the move begun at reset
               semp_pkg::REG_DEFAULT_TARGET: begin
                  if (default_move_ff) goal_ff <= clamp_deg(csr_data[semp_pkg::DEG_W-1:0]);
               end
               semp_pkg::REG_DEFAULT_DURATION: begin
                  if (default_move_ff) duration_ff <= csr_data;
               end
               default: ;
            endcase
         end
         if (cmd.load) begin
            if (req_action) begin
               start_pos_ff    <= cur_pos_ff;
               goal_ff         <= clamp_deg(req_goal_deg);
               duration_ff     <= req_duration_ms;
               mode_ff         <= req_ease_mode;
               elapsed_ff      <= '0;
               default_move_ff <= 1'b0;
            end else begin
               elapsed_ff <= elapsed_sum[DW] ? {DW{1'b1}} : elapsed_sum[DW-1:0];
            end
         end
         if (cmd.pos_wr) begin
            cur_pos_ff <= moving_up ? (start_pos_ff + delta) : (start_pos_ff - delta);
         end
      end
   end

   // restoring divider, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.div_init) begin
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff  <= {1'b0, elapsed_ff};
         quo_ff  <= '0;
         full_ff <= elapsed_ff >= dur_eff;
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? (rem_dbl - {1'b0, dur_eff}) : rem_dbl;
         quo_ff <= {quo_ff[FRAC_BITS-2:0], rem_ge};
      end
      if (cmd.ease_lo) begin
         ease_ff <= (mode_ff == semp_pkg::CURVE_LIN) ? t_val : prod_frac;
      end else if (cmd.ease_hi && (mode_ff == semp_pkg::CURVE_SMOOTH)) begin
         ease_ff <= prod_frac;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_pulse_us     <= semp_pkg::PULSE_BASE +
                             semp_pkg::PULSE_W'(prod_ff[semp_pkg::RECIP_SHIFT +:
                                                        semp_pkg::PULSE_OFS_W]);
         rsp_position_q16 <= cur_pos_ff;
         rsp_move_done    <= full_ff;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/servo_eased_motion_profile.sv
// ============================================================================
// servo_eased_motion_profile - eased servo trajectory generator
// Tick and new-target beats in, one position/pulse beat out per input beat.
// ============================================================================
// Usage:
//  - req_* stream: one beat per tick (req_tuser = 0) or new target command
//    (req_tuser = 1). Every accepted beat yields exactly one rsp_* beat.
//  - rsp_* stream: pulse width, Q9.16 position and the move-done flag.
//  - csr_* write channel: index 0 update period, 1 default target,
//    2 default duration; other indexes are dropped. csr_ready is always high.
//    Write only while no beat is in flight.
//  - Sequence: a req beat passes through the bit-serial divider (FRAC_BITS
//    quotient bits) and then the shared multiplier (five products in sequence)
//    before rsp_tvalid. One beat is worked at a time; req_tready is high only
//    while the sequencer is idle, so the next beat waits until the last result is loaded.
//  - Stall: the result sits in an output register; the next req beat is
//    accepted and processed while it waits, and the sequencer holds before
//    overwriting it until rsp_tready.
//  - Reset (synchronous): registers take their defaults and a linear move
//    from 0 degrees toward the default target begins. No clearing pass.
// ============================================================================
`default_nettype none

module servo_eased_motion_profile #(
   parameter int FRAC_BITS = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // req_tdata: goal angle[8:0], duration_ms[24:9], ease_mode[26:25], zero pad
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [semp_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_tuser: action (0 tick, 1 new target)
   input  wire                                  req_tuser,
   // rsp_tdata: pulse_us[11:0], position_q16[36:12], move_done[37], zero pad
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [semp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // config write channel
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [semp_pkg::IDX_W-1:0]           csr_index,
   input  wire  [semp_pkg::CFG_W-1:0]           csr_data
);

   semp_pkg::cmd_type  cmd;
   semp_pkg::stat_type stat;

   logic [semp_pkg::PULSE_W-1:0] pulse_us;
   logic [semp_pkg::POS_W-1:0]   position_q16;
   logic                         move_done;

   // config writes never stall
   assign csr_ready = 1'b1;

   semp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   semp_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_action       (req_tuser),
      .req_goal_deg     (req_tdata[8:0]),
      .req_duration_ms  (req_tdata[24:9]),
      .req_ease_mode    (req_tdata[26:25]),
      .csr_wr           (csr_valid & csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_pulse_us     (pulse_us),
      .rsp_position_q16 (position_q16),
      .rsp_move_done    (move_done)
   );

   // pack result fields, lowest first
   assign rsp_tdata = {2'b00, move_done, position_q16, pulse_us};

endmodule

`default_nettype wire
